// ===== rtl/core/rectangle_raster_canvas_assert.svh =====
// Assertion macros for the rectangle raster canvas.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef RECTANGLE_RASTER_CANVAS_ASSERT_SVH
`define RECTANGLE_RASTER_CANVAS_ASSERT_SVH

// Same-cycle implication, held off during reset
`define RRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define RRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rrc_pkg.sv =====
package rrc_pkg;

    // Canvas geometry
    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;
    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int ADDR_BITS = COL_BITS + ROW_BITS;

    // Field widths
    localparam int FRAC_BITS = 8;
    localparam int CRD_W     = 20;
    localparam int AW        = CRD_W + 2;
    localparam int CHAR_W    = 8;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(MAX_COLS - 1);
    localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(MAX_ROWS - 1);
    localparam logic signed [AW-1:0] ONE_FX  = AW'(1 << FRAC_BITS);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_DRAW  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_RECT = 2'd1;
    localparam logic [STAT_W-1:0] ST_OUTSIDE  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

    // Shape characters
    localparam logic [CHAR_W-1:0] CH_FILLED  = 8'h52;
    localparam logic [CHAR_W-1:0] CH_OUTLINE = 8'h72;

    // What a request turns into once decoded
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_SCAN = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic rd;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  last;
    } t_dp_stat;

    // Last in-use column: 0 acts as 1, above the maximum acts as the maximum
    function automatic logic [COL_BITS-1:0] cols_last(input logic [CFG_W-1:0] n);
        logic [CFG_W-1:0] m;
        m = n - CFG_W'(1);
        if (n == '0) begin
            return '0;
        end else if (32'(n) > MAX_COLS) begin
            return COL_LAST;
        end
        return m[COL_BITS-1:0];
    endfunction

    function automatic logic [ROW_BITS-1:0] rows_last(input logic [CFG_W-1:0] n);
        logic [CFG_W-1:0] m;
        m = n - CFG_W'(1);
        if (n == '0) begin
            return '0;
        end else if (32'(n) > MAX_ROWS) begin
            return ROW_LAST;
        end
        return m[ROW_BITS-1:0];
    endfunction

endpackage

// ===== rtl/core/rectangle_raster_canvas.sv =====
// Character canvas rasterizer. After reset the block sweeps all 65536 canvas cells to
// zero, holding o_busy high during the sweep; configuration writes are taken during the
// sweep. A request is taken when i_start is high and o_busy is low. Draw and clear visit
// every in-use pixel, one per cycle through the single canvas write port, where a size
// of 0 counts as 1 and one above 256 as 256; a read goes through a registered memory
// read, and an invalid draw or unused action goes from dispatch straight to done. The
// result (o_status, o_pixel_value) is valid only in the single cycle o_done is high;
// there is no way to stall it, so capture it then. Write configuration only while
// o_busy is low.
`include "rectangle_raster_canvas_assert.svh"

module rectangle_raster_canvas (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [rrc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rrc_pkg::CFG_W-1:0]           i_cfg_data,
    // request
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [rrc_pkg::ACT_W-1:0]           i_action,
    input  logic [rrc_pkg::CHAR_W-1:0]          i_shape_char,
    input  logic signed [rrc_pkg::CRD_W-1:0]    i_left_x,
    input  logic signed [rrc_pkg::CRD_W-1:0]    i_top_y,
    input  logic signed [rrc_pkg::CRD_W-1:0]    i_rect_width,
    input  logic signed [rrc_pkg::CRD_W-1:0]    i_rect_height,
    input  logic [rrc_pkg::CHAR_W-1:0]          i_ink_char,
    input  logic [rrc_pkg::CHAR_W-1:0]          i_read_col,
    input  logic [rrc_pkg::CHAR_W-1:0]          i_read_row,
    // result
    output logic                                o_done,
    output logic [rrc_pkg::STAT_W-1:0]          o_status,
    output logic [rrc_pkg::CHAR_W-1:0]          o_pixel_value
);
    import rrc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer
    rrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    // Canvas, counters and coverage logic
    rrc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_action),
        .i_shape_char  (i_shape_char),
        .i_left_x      (i_left_x),
        .i_top_y       (i_top_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_ink_char    (i_ink_char),
        .i_read_col    (i_read_col),
        .i_read_row    (i_read_row),
        .o_status      (o_status),
        .o_pixel_value (o_pixel_value)
    );

    // Checks
    `RRC_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "request taken but not busy")
    `RRC_ASSERT_NEXT(a_done_single, o_done, !o_done && !o_busy, "result strobe not one cycle")
    `RRC_ASSERT_NOW(a_done_in_busy, o_done, o_busy, "result strobe while idle")
    `RRC_ASSERT_NOW(a_outside_zero, o_done && (o_status == ST_OUTSIDE),
                    o_pixel_value == '0, "outside read returned a pixel")

endmodule

// ===== rtl/core/rrc_ctrl.sv =====
module rrc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rrc_pkg::t_dp_stat i_stat,
    output rrc_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import rrc_pkg::*;

    typedef enum logic [5:0] {
        S_INIT     = 6'b000001,
        S_IDLE     = 6'b000010,
        S_DISPATCH = 6'b000100,
        S_SCAN     = 6'b001000,
        S_READ     = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // State register; reset starts the zeroing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.rd     = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.kind)
                    KIND_SCAN: n_state = S_SCAN;
                    KIND_READ: n_state = S_READ;
                    default:   n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) n_state = S_DONE;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// ===== rtl/core/rrc_datapath.sv =====
module rrc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [rrc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rrc_pkg::CFG_W-1:0]           i_cfg_data,
    // controller link
    input  rrc_pkg::t_dp_cmd                    i_cmd,
    output rrc_pkg::t_dp_stat                   o_stat,
    // request fields
    input  logic [rrc_pkg::ACT_W-1:0]           i_action,
    input  logic [rrc_pkg::CHAR_W-1:0]          i_shape_char,
    input  logic signed [rrc_pkg::CRD_W-1:0]    i_left_x,
    input  logic signed [rrc_pkg::CRD_W-1:0]    i_top_y,
    input  logic signed [rrc_pkg::CRD_W-1:0]    i_rect_width,
    input  logic signed [rrc_pkg::CRD_W-1:0]    i_rect_height,
    input  logic [rrc_pkg::CHAR_W-1:0]          i_ink_char,
    input  logic [rrc_pkg::CHAR_W-1:0]          i_read_col,
    input  logic [rrc_pkg::CHAR_W-1:0]          i_read_row,
    // result fields
    output logic [rrc_pkg::STAT_W-1:0]          o_status,
    output logic [rrc_pkg::CHAR_W-1:0]          o_pixel_value
);
    import rrc_pkg::*;

    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_FILL = 2'd1,
        MODE_DRAW = 2'd2
    } t_mode;

    // Configuration registers
    logic [CFG_W-1:0]  r_cfg_width;
    logic [CFG_W-1:0]  r_cfg_height;
    logic [CHAR_W-1:0] r_bg_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(256);
            r_cfg_height <= CFG_W'(256);
            r_bg_char    <= CHAR_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_HEIGHT: r_cfg_height <= i_cfg_data;
                REG_BG:     r_bg_char    <= i_cfg_data[CHAR_W-1:0];
                default:    ;
            endcase
        end
    end

    logic [COL_BITS-1:0] w_cfg_xlast;
    logic [ROW_BITS-1:0] w_cfg_ylast;
    assign w_cfg_xlast = cols_last(r_cfg_width);
    assign w_cfg_ylast = rows_last(r_cfg_height);

    // Request decode at accept: edges of the rectangle, kind and status
    logic signed [AW-1:0] w_lx, w_rx, w_ty, w_by;
    assign w_lx = AW'(i_left_x);
    assign w_ty = AW'(i_top_y);
    assign w_rx = w_lx + AW'(i_rect_width);
    assign w_by = w_ty + AW'(i_rect_height);

    logic              w_size_bad, w_shape_bad, w_outside;
    t_kind             n_kind;
    t_mode             n_mode;
    logic [STAT_W-1:0] n_status;
    logic              n_read_ok;

    assign w_size_bad  = i_rect_width[CRD_W-1] || (i_rect_width == '0) ||
                         i_rect_height[CRD_W-1] || (i_rect_height == '0);
    assign w_shape_bad = (i_shape_char != CH_FILLED) && (i_shape_char != CH_OUTLINE);
    assign w_outside   = (32'(i_read_col) > 32'(w_cfg_xlast)) ||
                         (32'(i_read_row) > 32'(w_cfg_ylast));

    always_comb begin
        n_kind    = KIND_NONE;
        n_mode    = MODE_DRAW;
        n_status  = ST_OK;
        n_read_ok = 1'b0;
        case (i_action)
            ACT_DRAW: begin
                if (w_size_bad || w_shape_bad) begin
                    n_status = ST_BAD_RECT;
                end else begin
                    n_kind = KIND_SCAN;
                end
            end
            ACT_READ: begin
                n_kind = KIND_READ;
                if (w_outside) begin
                    n_status = ST_OUTSIDE;
                end else begin
                    n_read_ok = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_kind = KIND_SCAN;
                n_mode = MODE_FILL;
            end
            default: ;
        endcase
    end

    // Latched request
    logic signed [AW-1:0] r_lx, r_lx1, r_rx, r_rx1;
    logic signed [AW-1:0] r_ty, r_ty1, r_by, r_by1;
    logic                 r_outline;
    logic [CHAR_W-1:0]    r_ink;
    logic [ADDR_BITS-1:0] r_raddr;
    t_kind                r_kind;
    logic [STAT_W-1:0]    r_status;
    logic                 r_read_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lx      <= w_lx;
            r_lx1     <= w_lx + ONE_FX;
            r_rx      <= w_rx;
            r_rx1     <= w_rx - ONE_FX;
            r_ty      <= w_ty;
            r_ty1     <= w_ty + ONE_FX;
            r_by      <= w_by;
            r_by1     <= w_by - ONE_FX;
            r_outline <= (i_shape_char == CH_OUTLINE);
            r_ink     <= i_ink_char;
            r_raddr   <= {ROW_BITS'(i_read_row), COL_BITS'(i_read_col)};
            r_kind    <= n_kind;
            r_status  <= n_status;
            r_read_ok <= n_read_ok;
        end
    end

    // Pixel scan counters and mode
    logic [COL_BITS-1:0] r_x;
    logic [ROW_BITS-1:0] r_y;
    t_mode               r_mode;
    logic [COL_BITS-1:0] w_xlast;
    logic [ROW_BITS-1:0] w_ylast;
    logic                w_xend, w_last;

    assign w_xlast = (r_mode == MODE_ZERO) ? COL_LAST : w_cfg_xlast;
    assign w_ylast = (r_mode == MODE_ZERO) ? ROW_LAST : w_cfg_ylast;
    assign w_xend  = (r_x == w_xlast);
    assign w_last  = w_xend && (r_y == w_ylast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_mode <= MODE_ZERO;
        end else if (i_cmd.accept) begin
            r_x    <= '0;
            r_y    <= '0;
            r_mode <= n_mode;
        end else if (i_cmd.step) begin
            if (w_xend) begin
                r_x <= '0;
                r_y <= r_y + ROW_BITS'(1);
            end else begin
                r_x <= r_x + COL_BITS'(1);
            end
        end
    end

    // Coverage of the current pixel
    logic signed [AW-1:0] w_px, w_py;
    logic w_in_x, w_in_y, w_edge_x, w_edge_y, w_cover;

    assign w_px     = AW'({r_x, {FRAC_BITS{1'b0}}});
    assign w_py     = AW'({r_y, {FRAC_BITS{1'b0}}});
    assign w_in_x   = (w_px >= r_lx) && (w_px <= r_rx);
    assign w_in_y   = (w_py >= r_ty) && (w_py <= r_by);
    assign w_edge_x = (w_px < r_lx1) || (w_px > r_rx1);
    assign w_edge_y = (w_py < r_ty1) || (w_py > r_by1);
    assign w_cover  = w_in_x && w_in_y && (!r_outline || w_edge_x || w_edge_y);

    // Write port of the canvas
    logic                 w_we;
    logic [CHAR_W-1:0]    w_wdata;
    logic [ADDR_BITS-1:0] w_waddr;

    assign w_waddr = {r_y, r_x};
    assign w_we    = i_cmd.step && ((r_mode != MODE_DRAW) || w_cover);

    always_comb begin
        case (r_mode)
            MODE_FILL: w_wdata = r_bg_char;
            MODE_DRAW: w_wdata = r_ink;
            default:   w_wdata = '0;
        endcase
    end

    // Canvas memory
    logic [CHAR_W-1:0] r_canvas [2**ADDR_BITS];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_canvas[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_canvas[r_raddr];
        end
    end

    // Status back to the controller and result fields
    assign o_stat.kind   = r_kind;
    assign o_stat.last   = w_last;
    assign o_status      = r_status;
    assign o_pixel_value = r_read_ok ? r_rdata : '0;

endmodule
